// ===== src/cln_pkg.sv =====
// Shared types, constants and lookup functions for the character LCD nibble sequencer.
// No dependencies.
`default_nettype none

package cln_pkg;

  localparam int unsigned COLUMNS = 40;

  typedef enum logic [3:0] {
    OP_INIT    = 4'd0,
    OP_COMMAND = 4'd1,
    OP_DATA    = 4'd2,
    OP_CLEAR   = 4'd3,
    OP_HOME    = 4'd4,
    OP_CURSOR  = 4'd5,
    OP_DISPLAY = 4'd6,
    OP_SHOWCUR = 4'd7,
    OP_BLINK   = 4'd8
  } op_e;

  localparam logic [3:0]  INIT_LAST_NIB = 4'd11;
  localparam logic [3:0]  BYTE_LAST_NIB = 4'd1;

  localparam logic [7:0]  CMD_CLEAR      = 8'h01;
  localparam logic [7:0]  CMD_HOME       = 8'h02;
  localparam logic [7:0]  CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0]  CMD_DISP_CTRL  = 8'h08;
  localparam logic [7:0]  CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0]  CMD_DDRAM_ADDR = 8'h80;
  localparam logic [2:0]  FLAG_DISPLAY   = 3'h4;
  localparam logic [2:0]  FLAG_CURSOR    = 3'h2;
  localparam logic [2:0]  FLAG_BLINK     = 3'h1;

  localparam logic [15:0] HOLD_STROBE  = 16'd1;
  localparam logic [15:0] HOLD_SETTLE  = 16'd50;
  localparam logic [15:0] HOLD_POWERUP = 16'd50000;
  localparam logic [15:0] EXTRA_WAKE   = 16'd5000;
  localparam logic [15:0] EXTRA_WAKE3  = 16'd60;
  localparam logic [15:0] EXTRA_SLOW   = 16'd2000;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       lead;
    logic [3:0] nib;
    logic [1:0] phase;
    logic       last;
  } cln_cmd_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] nib);
    logic [3:0] val;
    unique case (nib)
      4'd0, 4'd1, 4'd2: val = 4'h3;
      4'd3:             val = 4'h2;
      4'd4:             val = CMD_FUNC_SET[7:4];
      4'd5:             val = CMD_FUNC_SET[3:0];
      4'd6:             val = CMD_DISP_CTRL[7:4];
      4'd7:             val = CMD_DISP_CTRL[3:0] | {1'b0, FLAG_DISPLAY};
      4'd8:             val = CMD_CLEAR[7:4];
      4'd9:             val = CMD_CLEAR[3:0];
      4'd10:            val = CMD_ENTRY_MODE[7:4];
      4'd11:            val = CMD_ENTRY_MODE[3:0];
      default:          val = 4'h0;
    endcase
    return val;
  endfunction

  function automatic logic [15:0] init_extra(input logic [3:0] nib);
    logic [15:0] val;
    unique case (nib)
      4'd0, 4'd1: val = EXTRA_WAKE;
      4'd2:       val = EXTRA_WAKE3;
      4'd9:       val = EXTRA_SLOW;
      default:    val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/cln_ctrl.sv =====
// Step sequencer state machine: input handshake, step counters, output valid.
// Depends on cln_pkg.
`default_nettype none

module cln_ctrl
  import cln_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_init_i,
  input  wire logic     in_op_ok_i,
  output logic          in_ready_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output cln_cmd_t      cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e     state_q;
  logic       lead_q;
  logic       init_q;
  logic [3:0] nib_q;
  logic [1:0] phase_q;
  logic       out_valid_q;
  logic       accept;
  logic       load;
  logic       last;
  logic [3:0] last_nib;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign load        = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);
  assign last_nib    = init_q ? INIT_LAST_NIB : BYTE_LAST_NIB;
  assign last        = !lead_q && (phase_q == 2'd2) && (nib_q == last_nib);
  assign out_valid_o = out_valid_q;

  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;
  assign cmd_o.lead   = lead_q;
  assign cmd_o.nib    = nib_q;
  assign cmd_o.phase  = phase_q;
  assign cmd_o.last   = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lead_q      <= 1'b0;
      init_q      <= 1'b0;
      nib_q       <= 4'd0;
      phase_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && in_op_ok_i) begin
            state_q <= ST_RUN;
            lead_q  <= in_init_i;
            init_q  <= in_init_i;
            nib_q   <= 4'd0;
            phase_q <= 2'd0;
          end
        end
        ST_RUN: begin
          if (load) begin
            if (lead_q) begin
              lead_q <= 1'b0;
            end else if (phase_q == 2'd2) begin
              phase_q <= 2'd0;
              if (nib_q == last_nib) begin
                state_q <= ST_IDLE;
              end else begin
                nib_q <= nib_q + 4'd1;
              end
            end else begin
              phase_q <= phase_q + 2'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && last |=> state_q == ST_IDLE)
    else $error("run did not end after its last step");

  a_nib_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> nib_q <= last_nib && phase_q != 2'd3)
    else $error("step counters out of range");

  a_bad_op_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_op_ok_i |=> state_q == ST_IDLE && !load)
    else $error("undefined request started a run");

  a_lead_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_q |-> init_q && nib_q == 4'd0 && phase_q == 2'd0)
    else $error("lead-in step outside init");

endmodule

`default_nettype wire

// ===== src/cln_datapath.sv =====
// Request decode, display flags and output step registers.
// Depends on cln_pkg.
`default_nettype none

module cln_datapath
  import cln_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cln_cmd_t    cmd_i,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [5:0]  column_i,
  input  wire logic        row_select_i,
  input  wire logic        turn_on_i,
  output logic             register_select_o,
  output logic             enable_pin_o,
  output logic [3:0]       data_nibble_o,
  output logic [15:0]      hold_us_o,
  output logic             last_step_o
);

  logic [2:0]  flags_q, flags_d;
  logic [7:0]  byte_q, byte_d;
  logic        rs_q, rs_d;
  logic        slow_q, slow_d;
  logic        init_q, init_d;
  logic [5:0]  col_sat;
  logic [2:0]  flag_bit;

  logic        out_rs_q, out_en_q, out_last_q;
  logic [3:0]  out_nib_q;
  logic [15:0] out_hold_q;

  logic        step_rs, step_en;
  logic [3:0]  step_nib;
  logic [15:0] step_extra, step_hold;

  assign col_sat = ({1'b0, column_i} >= 7'(COLUMNS)) ? 6'(COLUMNS - 1) : column_i;

  always_comb begin
    flags_d  = flags_q;
    byte_d   = byte_value_i;
    rs_d     = 1'b0;
    slow_d   = 1'b0;
    init_d   = 1'b0;
    flag_bit = 3'd0;
    unique case (op_e'(opcode_i))
      OP_INIT: begin
        init_d  = 1'b1;
        flags_d = FLAG_DISPLAY;
      end
      OP_COMMAND: ;
      OP_DATA:    rs_d = 1'b1;
      OP_CLEAR: begin
        byte_d = CMD_CLEAR;
        slow_d = 1'b1;
      end
      OP_HOME: begin
        byte_d = CMD_HOME;
        slow_d = 1'b1;
      end
      OP_CURSOR: byte_d = CMD_DDRAM_ADDR | {1'b0, row_select_i, col_sat};
      OP_DISPLAY, OP_SHOWCUR, OP_BLINK: begin
        if (op_e'(opcode_i) == OP_DISPLAY) begin
          flag_bit = FLAG_DISPLAY;
        end else if (op_e'(opcode_i) == OP_SHOWCUR) begin
          flag_bit = FLAG_CURSOR;
        end else begin
          flag_bit = FLAG_BLINK;
        end
        flags_d = turn_on_i ? (flags_q | flag_bit) : (flags_q & ~flag_bit);
        byte_d  = CMD_DISP_CTRL | {5'd0, flags_d};
      end
      default: flags_d = flags_q;
    endcase
  end

  always_comb begin
    if (init_q) begin
      step_nib   = init_nibble(cmd_i.nib);
      step_extra = init_extra(cmd_i.nib);
    end else begin
      step_nib   = cmd_i.nib[0] ? byte_q[3:0] : byte_q[7:4];
      step_extra = (slow_q && cmd_i.nib[0]) ? EXTRA_SLOW : 16'd0;
    end
    step_rs   = rs_q;
    step_en   = (cmd_i.phase == 2'd1);
    step_hold = (cmd_i.phase == 2'd2) ? (HOLD_SETTLE + step_extra) : HOLD_STROBE;
    if (cmd_i.lead) begin
      step_rs   = 1'b0;
      step_en   = 1'b0;
      step_nib  = 4'h0;
      step_hold = HOLD_POWERUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= 3'd0;
    end else if (cmd_i.accept) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= byte_d;
      rs_q   <= rs_d;
      slow_q <= slow_d;
      init_q <= init_d;
    end
    if (cmd_i.load) begin
      out_rs_q   <= step_rs;
      out_en_q   <= step_en;
      out_nib_q  <= step_nib;
      out_hold_q <= step_hold;
      out_last_q <= cmd_i.last;
    end
  end

  assign register_select_o = out_rs_q;
  assign enable_pin_o      = out_en_q;
  assign data_nibble_o     = out_nib_q;
  assign hold_us_o         = out_hold_q;
  assign last_step_o       = out_last_q;

endmodule

`default_nettype wire

// ===== src/char_lcd_nibble_sequencer.sv =====
// Character LCD nibble sequencer, top level: stream ports, controller and datapath.
// Depends on cln_pkg, cln_ctrl and cln_datapath.
//
// Each request on the slave stream expands into pin steps for a 4-bit character LCD
// bus on the master stream. Every nibble is three steps (EN low 1 us, EN high 1 us,
// EN low 50 us or longer); tlast marks the final step of a request.
// Byte requests give 6 steps, init gives 37 (a 50 ms lead-in, four wake-up
// nibbles, then function set, display control, clear and entry mode).
// Undefined opcodes are accepted and give no steps.
// After a request is accepted, the sequencer enters its run state and then loads the
// first step into the output register when it is free. Throughput: one step per cycle
// while tready stays high; a request occupies the step counters for its whole run, so
// the single step sequencer takes the next request only once its last step is loaded.
// The output register holds a step while tready is low and the sequencer waits;
// the next request is taken as soon as the last step sits in that register.
// Reset clears the display flags, empties the output register and idles the
// sequencer.
`default_nettype none

module char_lcd_nibble_sequencer
  import cln_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // opcode, byte_value, column, row_select, turn_on
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // enable_pin, data_nibble, hold_us
  output logic             m_axis_tuser,  // register_select
  output logic             m_axis_tlast
);

  cln_cmd_t    cmd;
  logic [3:0]  opcode;
  logic        op_ok;
  logic        op_init;
  logic        enable_pin;
  logic [3:0]  data_nibble;
  logic [15:0] hold_us;

  assign opcode  = s_axis_tdata[3:0];
  assign op_ok   = (opcode <= OP_BLINK);
  assign op_init = (opcode == OP_INIT);

  cln_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_init_i   (op_init),
    .in_op_ok_i  (op_ok),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  cln_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (opcode),
    .byte_value_i      (s_axis_tdata[11:4]),
    .column_i          (s_axis_tdata[17:12]),
    .row_select_i      (s_axis_tdata[18]),
    .turn_on_i         (s_axis_tdata[19]),
    .register_select_o (m_axis_tuser),
    .enable_pin_o      (enable_pin),
    .data_nibble_o     (data_nibble),
    .hold_us_o         (hold_us),
    .last_step_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {3'd0, hold_us, data_nibble, enable_pin};

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for char_lcd_nibble_sequencer: LCD requests go in on the slave
// stream, and every pin step that comes out is checked against an in-bench step predictor.
// Depends on cln_pkg (op_e) and the RTL under src/.
`default_nettype none

module tb_top
  import cln_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QUIET_LIMIT   = 5000;
  localparam int          HOLDOFF_LEN   = 400;
  localparam int          PHASE_ITEMS   = 36;
  localparam int          LINE_COLUMNS  = 40;

  localparam logic [7:0]  LCD_CLEAR     = 8'h01;
  localparam logic [7:0]  LCD_HOME      = 8'h02;
  localparam logic [7:0]  LCD_ENTRY     = 8'h06;
  localparam logic [7:0]  LCD_DISP_CTRL = 8'h08;
  localparam logic [7:0]  LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0]  LCD_SET_ADDR  = 8'h80;
  localparam logic [7:0]  ROW1_OFFSET   = 8'h40;
  localparam logic [3:0]  WAKE_NIB      = 4'h3;
  localparam logic [3:0]  BUS4_NIB      = 4'h2;
  localparam logic [2:0]  DISP_ON_BIT   = 3'h4;
  localparam logic [2:0]  CURSOR_BIT    = 3'h2;
  localparam logic [2:0]  BLINK_BIT     = 3'h1;
  localparam logic [15:0] T_STROBE      = 16'd1;
  localparam logic [15:0] T_SETTLE      = 16'd50;
  localparam logic [15:0] T_POWERUP     = 16'd50000;
  localparam logic [15:0] T_WAKE        = 16'd5000;
  localparam logic [15:0] T_WAKE3       = 16'd60;
  localparam logic [15:0] T_SLOW        = 16'd2000;

  typedef struct packed {
    logic       turn_on;
    logic       row_sel;
    logic [5:0] column;
    logic [7:0] byte_val;
    logic [3:0] opcode;
  } lcd_req_t;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } pin_step_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  lcd_req_t  pending_reqs[$];
  pin_step_t expected_steps[$];
  pin_step_t run_buf[0:63];
  int        run_len;
  logic [2:0] lcd_flags     = '0;
  int        src_idle_pct  = 0;
  int        snk_stall_pct = 0;
  int        holdoff_req   = 0;
  int        holdoff_seen  = 0;
  int        holdoff_left  = 0;
  int        quiet_cycles  = 0;
  int        mismatches    = 0;

  char_lcd_nibble_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void add_step(logic rs, logic en, logic [3:0] nib, logic [15:0] hold);
    run_buf[run_len] = '{rs: rs, en: en, nib: nib, hold: hold, last: 1'b0};
    run_len++;
  endfunction

  function automatic void add_nibble(logic rs, logic [3:0] nib, logic [15:0] extra);
    add_step(rs, 1'b0, nib, T_STROBE);
    add_step(rs, 1'b1, nib, T_STROBE);
    add_step(rs, 1'b0, nib, T_SETTLE + extra);
  endfunction

  function automatic void add_byte(logic rs, logic [7:0] b, logic [15:0] extra);
    add_nibble(rs, b[7:4], '0);
    add_nibble(rs, b[3:0], extra);
  endfunction

  function automatic void predict_steps(lcd_req_t r);
    logic [5:0] col;
    logic [2:0] flag_bit;
    run_len = 0;
    col = (r.column >= LINE_COLUMNS) ? 6'(LINE_COLUMNS - 1) : r.column;
    case (r.opcode)
      OP_INIT: begin
        add_step(1'b0, 1'b0, 4'h0, T_POWERUP);
        add_nibble(1'b0, WAKE_NIB, T_WAKE);
        add_nibble(1'b0, WAKE_NIB, T_WAKE);
        add_nibble(1'b0, WAKE_NIB, T_WAKE3);
        add_nibble(1'b0, BUS4_NIB, '0);
        add_byte(1'b0, LCD_FUNC_SET, '0);
        lcd_flags = DISP_ON_BIT;
        add_byte(1'b0, LCD_DISP_CTRL | {5'b0, lcd_flags}, '0);
        add_byte(1'b0, LCD_CLEAR, T_SLOW);
        add_byte(1'b0, LCD_ENTRY, '0);
      end
      OP_COMMAND: add_byte(1'b0, r.byte_val, '0);
      OP_DATA:    add_byte(1'b1, r.byte_val, '0);
      OP_CLEAR:   add_byte(1'b0, LCD_CLEAR, T_SLOW);
      OP_HOME:    add_byte(1'b0, LCD_HOME, T_SLOW);
      OP_CURSOR:  add_byte(1'b0, LCD_SET_ADDR | ((r.row_sel ? ROW1_OFFSET : 8'h00) + {2'b0, col}),
                           '0);
      OP_DISPLAY, OP_SHOWCUR, OP_BLINK: begin
        flag_bit = (r.opcode == OP_DISPLAY) ? DISP_ON_BIT :
                   (r.opcode == OP_SHOWCUR) ? CURSOR_BIT : BLINK_BIT;
        lcd_flags = r.turn_on ? (lcd_flags | flag_bit) : (lcd_flags & ~flag_bit);
        add_byte(1'b0, LCD_DISP_CTRL | {5'b0, lcd_flags}, '0);
      end
      default: ;
    endcase
    if (run_len > 0) run_buf[run_len-1].last = 1'b1;
    for (int i = 0; i < run_len; i++) expected_steps.push_back(run_buf[i]);
  endfunction

  function automatic lcd_req_t mk_req(logic [3:0] op, logic [7:0] bv, logic [5:0] col,
                                      logic row, logic on);
    return '{turn_on: on, row_sel: row, column: col, byte_val: bv, opcode: op};
  endfunction

  function automatic lcd_req_t random_request();
    int pick;
    logic [3:0] op;
    pick = $urandom_range(99);
    if (pick < 8)       op = OP_INIT;
    else if (pick < 14) op = 4'($urandom_range(15, 9));
    else                op = 4'($urandom_range(OP_BLINK, OP_COMMAND));
    return mk_req(op, 8'($urandom), 6'($urandom_range(63)), 1'($urandom), 1'($urandom));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_steps(lcd_req_t'(s_axis_tdata[19:0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, pending_reqs.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      holdoff_left  <= 0;
      holdoff_seen  <= 0;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen  <= holdoff_req;
      holdoff_left  <= HOLDOFF_LEN;
      m_axis_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left  <= holdoff_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    pin_step_t got;
    pin_step_t want;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{rs: m_axis_tuser, en: m_axis_tdata[0], nib: m_axis_tdata[4:1],
                hold: m_axis_tdata[20:5], last: m_axis_tlast};
        if (expected_steps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected pin step rs=%0b en=%0b nib=%h hold=%0d last=%0b",
                   $time, got.rs, got.en, got.nib, got.hold, got.last);
        end else begin
          want = expected_steps.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: pin step mismatch: expected rs=%0b en=%0b nib=%h hold=%0d last=%0b",
                     $time, want.rs, want.en, want.nib, want.hold, want.last);
            $display("%0t:                    actual   rs=%0b en=%0b nib=%h hold=%0d last=%0b",
                     $time, got.rs, got.en, got.nib, got.hold, got.last);
          end
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_steps.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(int src_pct, int snk_pct, bit squeeze);
    int defined_cnt;
    lcd_req_t r;
    @(negedge clk_i);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (squeeze) holdoff_req++;
    defined_cnt = 0;
    while (defined_cnt < PHASE_ITEMS) begin
      r = random_request();
      pending_reqs.push_back(r);
      if (r.opcode <= OP_BLINK) defined_cnt++;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // flags before init, then init and every request kind at its extremes
    pending_reqs.push_back(mk_req(OP_BLINK,   8'h00, 6'd0,  1'b0, 1'b1));
    pending_reqs.push_back(mk_req(OP_SHOWCUR, 8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_DISPLAY, 8'h00, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_INIT,    8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_COMMAND, 8'h00, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_COMMAND, 8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_COMMAND, LCD_CLEAR, 6'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_COMMAND, LCD_HOME,  6'd0, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_DATA,    8'h00, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_DATA,    8'hFF, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_DATA,    8'hA5, 6'd21, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(OP_CLEAR,   8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_HOME,    8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(OP_CURSOR,  8'hFF, 6'd0,  1'b0, 1'b1));
    pending_reqs.push_back(mk_req(OP_CURSOR,  8'h00, 6'd39, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(OP_CURSOR,  8'h00, 6'd40, 1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_CURSOR,  8'h00, 6'd63, 1'b1, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHOWCUR, 8'h00, 6'd0,  1'b0, 1'b1));
    pending_reqs.push_back(mk_req(OP_BLINK,   8'h00, 6'd0,  1'b0, 1'b1));
    pending_reqs.push_back(mk_req(OP_DISPLAY, 8'h00, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_DISPLAY, 8'h00, 6'd0,  1'b0, 1'b1));
    pending_reqs.push_back(mk_req(OP_BLINK,   8'h00, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(4'd9,       8'hFF, 6'd63, 1'b1, 1'b1));
    pending_reqs.push_back(mk_req(4'd15,      8'h00, 6'd0,  1'b0, 1'b0));
    pending_reqs.push_back(mk_req(OP_SHOWCUR, 8'h00, 6'd0,  1'b0, 1'b0));
    drain();

    run_phase(0, 0, 1'b0);
    run_phase(52, 0, 1'b0);
    run_phase(0, 52, 1'b1);
    run_phase(35, 35, 1'b0);

    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
